@@ sv/lgr_pkg.sv @@
package lgr_pkg;

  localparam int unsigned ROW_W   = 64;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned COUNT_W = 4;

  // B3/S23 rule
  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);

  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic [IDX_W-1:0] idx;
    logic             last;
  } out_beat_t;

endpackage

@@ sv/life_generation_row_engine.sv @@
// Life B3/S23 next-generation engine, one grid row per input beat, row 0 first. Every
// column of a row is evaluated in the same cycle by one neighbor-count lane per
// interior column, so an input beat is taken every cycle that in_ready_o is high; the
// next-generation row for row r-1 enters the output queue in the cycle row r is
// accepted and can leave on the following edge. The first row of a generation yields
// no output, the second yields the dead border row 0, and the final row yields two beats
// (row GRID_SIZE-2 and the dead row GRID_SIZE-1 with last_row_o set). in_ready_o is high
// while the four-entry output queue has room for two beats. A generation gives exactly
// as many output beats as it takes input rows, so with the output side taking a beat per
// cycle the input sustains one row per cycle without a stall.
module life_generation_row_engine
  import lgr_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ROW_W-1:0] row_bits_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ROW_W-1:0] next_row_bits_o,
  output logic [IDX_W-1:0] out_row_index_o,
  output logic             last_row_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);

  logic [GRID_SIZE-1:0] row_above_q, row_above_d;
  logic [GRID_SIZE-1:0] row_middle_q, row_middle_d;
  logic [IDX_W-1:0]     row_count_q, row_count_d;

  logic [GRID_SIZE-1:0] row_in;
  logic [ROW_W-1:0]     gen_row;
  logic                 accept;
  logic                 is_first, is_second, is_final;
  logic                 push0, push1;
  out_beat_t            beat0, beat1, beat_out;

  assign accept = in_valid_i && in_ready_o;
  assign row_in = row_bits_i[GRID_SIZE-1:0];

  lgr_row #(
    .GRID_SIZE(GRID_SIZE)
  ) u_row (
    .up_i  (row_above_q),
    .mid_i (row_middle_q),
    .down_i(row_in),
    .next_o(gen_row)
  );

  assign is_first  = (row_count_q == '0);
  assign is_second = (row_count_q == IDX_W'(1));
  assign is_final  = (row_count_q == LAST_IDX);

  assign push0 = accept && !is_first;
  assign push1 = accept && is_final;

  always_comb begin
    beat0.bits = is_second ? '0 : gen_row;
    beat0.idx  = row_count_q - IDX_W'(1);
    beat0.last = 1'b0;
    beat1.bits = '0;
    beat1.idx  = LAST_IDX;
    beat1.last = 1'b1;
  end

  always_comb begin
    row_above_d  = row_above_q;
    row_middle_d = row_middle_q;
    row_count_d  = row_count_q;
    if (accept) begin
      row_above_d  = row_middle_q;
      row_middle_d = row_in;
      row_count_d  = is_final ? '0 : row_count_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_above_q  <= '0;
      row_middle_q <= '0;
      row_count_q  <= '0;
    end else begin
      row_above_q  <= row_above_d;
      row_middle_q <= row_middle_d;
      row_count_q  <= row_count_d;
    end
  end

  lgr_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(push0),
    .beat0_i(beat0),
    .push1_i(push1),
    .beat1_i(beat1),
    .room2_o(in_ready_o),
    .valid_o(out_valid_o),
    .beat_o (beat_out),
    .ready_i(out_ready_i)
  );

  assign next_row_bits_o = beat_out.bits;
  assign out_row_index_o = beat_out.idx;
  assign last_row_o      = beat_out.last;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_count_q <= LAST_IDX)
    else $error("row counter past final row");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_row_o) |-> (out_row_index_o == LAST_IDX))
    else $error("last_row beat not on final row");

  a_border_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_row_index_o == '0 || out_row_index_o == LAST_IDX))
      |-> (next_row_bits_o == '0))
    else $error("border row not dead");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_final) |=> (row_count_q == '0))
    else $error("row counter did not wrap after final row");

endmodule

@@ sv/lgr_cell.sv @@
module lgr_cell
  import lgr_pkg::*;
(
  input  logic [2:0] up_i,
  input  logic [2:0] mid_i,
  input  logic [2:0] down_i,
  output logic       alive_o
);

  logic [COUNT_W-1:0] count;

  // eight neighbors; the center cell is mid_i[1]
  assign count = COUNT_W'(up_i[0]) + COUNT_W'(up_i[1]) + COUNT_W'(up_i[2])
               + COUNT_W'(mid_i[0]) + COUNT_W'(mid_i[2])
               + COUNT_W'(down_i[0]) + COUNT_W'(down_i[1]) + COUNT_W'(down_i[2]);

  assign alive_o = (count == BIRTH_COUNT) || (mid_i[1] && (count == SURVIVE_COUNT));

endmodule

@@ sv/lgr_row.sv @@
module lgr_row
  import lgr_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic [GRID_SIZE-1:0] up_i,
  input  logic [GRID_SIZE-1:0] mid_i,
  input  logic [GRID_SIZE-1:0] down_i,
  output logic [ROW_W-1:0]     next_o
);

  logic [GRID_SIZE-1:0] lane;

  // border columns never live
  assign lane[0]           = 1'b0;
  assign lane[GRID_SIZE-1] = 1'b0;

  for (genvar c = 1; c <= GRID_SIZE - 2; c++) begin : g_lane
    lgr_cell u_cell (
      .up_i   (up_i[c+1:c-1]),
      .mid_i  (mid_i[c+1:c-1]),
      .down_i (down_i[c+1:c-1]),
      .alive_o(lane[c])
    );
  end

  // merge lanes into the full-width row, columns past the grid stay zero
  assign next_o = ROW_W'(lane);

endmodule

@@ sv/lgr_outq.sv @@
module lgr_outq
  import lgr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push0_i,
  input  out_beat_t beat0_i,
  input  logic      push1_i,
  input  out_beat_t beat1_i,
  output logic      room2_o,
  output logic      valid_o,
  output out_beat_t beat_o,
  input  logic      ready_i
);

  out_beat_t        entry_q [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign beat_o  = entry_q[rd_ptr_q];
  assign room2_o = (cnt_q <= CNT_W'(OUTQ_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + PTR_W'(push0_i) + PTR_W'(push1_i);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign cnt_d    = cnt_q + CNT_W'(push0_i) + CNT_W'(push1_i) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // second beat always lands right behind the first
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      entry_q[wr_ptr_q] <= beat0_i;
    end
    if (push1_i) begin
      entry_q[wr_ptr_q + PTR_W'(1)] <= beat1_i;
    end
  end

  a_push1_with_push0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second beat pushed without first");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> (cnt_q <= CNT_W'(OUTQ_DEPTH - 2)))
    else $error("push into queue without room");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OUTQ_DEPTH))
    else $error("queue count out of range");

endmodule
